FILE: sv/tcw_pkg.sv
// Shared types and constants of the text console writer.
package tcw_pkg;

    // Fixed payload widths
    localparam int REQ_W  = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int PX_W   = 7;
    localparam int PY_W   = 5;
    localparam int HW_W   = 11;
    localparam int CELL_W = CHAR_W + ATTR_W;

    // Character codes
    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
    localparam logic [CHAR_W-1:0] LINE_FEED  = 8'h0A;
    localparam logic [CHAR_W-1:0] CARR_RET   = 8'h0D;

    // Attribute after reset
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_PUT   = 2'd0,
        REQ_MOVE  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDATA,
        S_SCROLL,
        S_BLANK,
        S_CLEAR,
        S_HOLD
    } t_state;

endpackage

FILE: sv/tcw_if.sv
// Handshake channels of the text console writer: request, response, attribute write.
interface tcw_req_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::REQ_W-1:0]     req_type;
    logic [tcw_pkg::CHAR_W-1:0]    char_code;
    logic [tcw_pkg::PX_W-1:0]      pos_x;
    logic [tcw_pkg::PY_W-1:0]      pos_y;

    modport source (output valid, req_type, char_code, pos_x, pos_y, input ready);
    modport sink   (input valid, req_type, char_code, pos_x, pos_y, output ready);
endinterface

interface tcw_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::HW_W-1:0]      cursor_pos;
    logic [tcw_pkg::CHAR_W-1:0]    read_char;
    logic [tcw_pkg::ATTR_W-1:0]    read_attr;
    logic                          scrolled;

    modport source (output valid, cursor_pos, read_char, read_attr, scrolled, input ready);
    modport sink   (input valid, cursor_pos, read_char, read_attr, scrolled, output ready);
endinterface

interface tcw_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::ATTR_W-1:0]    text_attr;

    modport source (output valid, text_attr, input ready);
    modport sink   (input valid, text_attr, output ready);
endinterface

FILE: sv/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/tcw_lin_addr.sv
// Shared address unit: linear cell index from column and row.
module tcw_lin_addr #(
    parameter int NUM_COLS = 80,
    parameter int CW       = 7,
    parameter int RW       = 5,
    parameter int AW       = 11
) (
    input  logic [CW-1:0] i_col,
    input  logic [RW-1:0] i_row,
    output logic [AW-1:0] o_lin
);

    logic [AW-1:0] w_prod;

    // Row times a constant width, then add the column
    assign w_prod = AW'(i_row) * AW'(NUM_COLS);
    assign o_lin  = w_prod + AW'(i_col);

endmodule

FILE: sv/text_console_writer.sv
// Top level of the text console writer: sequencer, cursor state and cell memory.
//
// Text console over a NUM_COLS x NUM_ROWS memory of 16-bit cells (character in the
// low byte, attribute in the high byte). One request is in work at a time; the
// request channel is ready only while the sequencer is idle, and a finished
// response sits in an output register so the next request can be taken while it
// waits. Put character and move cursor finish in the execute state; read cell goes
// on to the read-data state and finishes there. A put that arrives with the cursor
// below the last row first scrolls: every cell of rows 1 and up is copied one row
// up and the bottom row is blanked, one cell per cycle through the single write
// port of the cell memory. Clear screen blanks every cell the same way. The cell
// memory powers up undefined; read a cell only after a clear or a write to it.
// Attribute writes are taken at any time and should be issued only while no
// request is in work.
module text_console_writer #(
    parameter int NUM_COLS = 80,
    parameter int NUM_ROWS = 25
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    tcw_req_if.sink  i_req,
    tcw_rsp_if.source o_rsp,
    tcw_cfg_if.sink  i_cfg
);

    localparam int CELLS  = NUM_COLS * NUM_ROWS;
    localparam int COPY_N = NUM_COLS * (NUM_ROWS - 1);
    localparam int CW     = $clog2(NUM_COLS);
    localparam int RW     = $clog2(NUM_ROWS + 1);
    localparam int AW     = $clog2(CELLS);
    localparam int HW     = tcw_pkg::HW_W;
    localparam int CHW    = tcw_pkg::CHAR_W;
    localparam int ATW    = tcw_pkg::ATTR_W;

    // Registers and next values
    tcw_pkg::t_state r_state, n_state;
    tcw_pkg::t_req   r_req_type, n_req_type;
    logic [CHW-1:0]  r_char, n_char;
    logic [CW-1:0]   r_satx, n_satx;
    logic [RW-1:0]   r_saty, n_saty;
    logic            r_in_rng, n_in_rng;
    logic [CW-1:0]   r_col, n_col;
    logic [RW-1:0]   r_row, n_row;
    logic [HW-1:0]   r_hw, n_hw;
    logic [ATW-1:0]  r_attr;
    logic [AW-1:0]   r_idx, n_idx;
    logic            r_cp_vld, n_cp_vld;
    logic [AW-1:0]   r_cp_addr, n_cp_addr;
    logic            r_scrolled, n_scrolled;
    logic [CHW-1:0]  r_res_char, n_res_char;
    logic [ATW-1:0]  r_res_attr, n_res_attr;
    logic            r_o_valid, n_o_valid;
    logic [HW-1:0]   r_o_cursor, n_o_cursor;
    logic [CHW-1:0]  r_o_char, n_o_char;
    logic [ATW-1:0]  r_o_attr, n_o_attr;
    logic            r_o_scrolled, n_o_scrolled;

    // Memory and address unit wiring
    logic                          w_we;
    logic [AW-1:0]                 w_waddr;
    logic [tcw_pkg::CELL_W-1:0]    w_wdata;
    logic [AW-1:0]                 w_raddr;
    logic [tcw_pkg::CELL_W-1:0]    w_rdata;
    logic [CW-1:0]                 w_lin_col;
    logic [RW-1:0]                 w_lin_row;
    logic [AW-1:0]                 w_lin;
    logic [AW:0]                   w_lin_inc;
    logic [tcw_pkg::CELL_W-1:0]    w_blank;
    logic                          w_out_free;
    logic                          w_fin;
    logic [CHW-1:0]                w_f_char;
    logic [ATW-1:0]                w_f_attr;
    logic                          w_newline;

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    tcw_lin_addr #(
        .NUM_COLS (NUM_COLS),
        .CW       (CW),
        .RW       (RW),
        .AW       (AW)
    ) u_lin (
        .i_col (w_lin_col),
        .i_row (w_lin_row),
        .o_lin (w_lin)
    );

    assign w_blank    = {r_attr, tcw_pkg::BLANK_CHAR};
    assign w_lin_inc  = {1'b0, w_lin} + (AW+1)'(1);
    assign w_out_free = !r_o_valid || o_rsp.ready;
    assign w_newline  = (r_char == tcw_pkg::LINE_FEED) || (r_char == tcw_pkg::CARR_RET);

    // Put uses the live cursor; move and read use the clamped request position
    assign w_lin_col = (r_req_type == tcw_pkg::REQ_PUT) ? r_col : r_satx;
    assign w_lin_row = (r_req_type == tcw_pkg::REQ_PUT) ? r_row : r_saty;

    // Attribute register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= tcw_pkg::ATTR_RESET;
        end else if (i_cfg.valid) begin
            r_attr <= i_cfg.text_attr;
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tcw_pkg::S_IDLE;
            r_col      <= '0;
            r_row      <= '0;
            r_hw       <= '0;
            r_cp_vld   <= 1'b0;
            r_o_valid  <= 1'b0;
            r_scrolled <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_col      <= n_col;
            r_row      <= n_row;
            r_hw       <= n_hw;
            r_cp_vld   <= n_cp_vld;
            r_o_valid  <= n_o_valid;
            r_scrolled <= n_scrolled;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req_type   <= n_req_type;
        r_char       <= n_char;
        r_satx       <= n_satx;
        r_saty       <= n_saty;
        r_in_rng     <= n_in_rng;
        r_idx        <= n_idx;
        r_cp_addr    <= n_cp_addr;
        r_res_char   <= n_res_char;
        r_res_attr   <= n_res_attr;
        r_o_cursor   <= n_o_cursor;
        r_o_char     <= n_o_char;
        r_o_attr     <= n_o_attr;
        r_o_scrolled <= n_o_scrolled;
    end

    // Sequencer: next state, memory port and cursor updates
    always_comb begin
        n_state      = r_state;
        n_req_type   = r_req_type;
        n_char       = r_char;
        n_satx       = r_satx;
        n_saty       = r_saty;
        n_in_rng     = r_in_rng;
        n_col        = r_col;
        n_row        = r_row;
        n_hw         = r_hw;
        n_idx        = r_idx;
        n_cp_vld     = r_cp_vld;
        n_cp_addr    = r_cp_addr;
        n_scrolled   = r_scrolled;
        n_res_char   = r_res_char;
        n_res_attr   = r_res_attr;
        n_o_valid    = r_o_valid && !o_rsp.ready;
        n_o_cursor   = r_o_cursor;
        n_o_char     = r_o_char;
        n_o_attr     = r_o_attr;
        n_o_scrolled = r_o_scrolled;
        i_req.ready  = 1'b0;
        w_we         = 1'b0;
        w_waddr      = r_idx;
        w_wdata      = w_blank;
        w_raddr      = AW'(r_idx + AW'(NUM_COLS));
        w_fin        = 1'b0;
        w_f_char     = '0;
        w_f_attr     = '0;

        unique case (r_state)
            tcw_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_req_type = tcw_pkg::t_req'(i_req.req_type);
                    n_char     = i_req.char_code;
                    n_satx     = (i_req.pos_x < NUM_COLS) ? CW'(i_req.pos_x)
                                                          : CW'(NUM_COLS - 1);
                    n_saty     = (i_req.pos_y < NUM_ROWS) ? RW'(i_req.pos_y)
                                                          : RW'(NUM_ROWS - 1);
                    n_in_rng   = (i_req.pos_x < NUM_COLS) && (i_req.pos_y < NUM_ROWS);
                    n_scrolled = 1'b0;
                    n_idx      = '0;
                    if ((i_req.req_type == tcw_pkg::REQ_PUT) &&
                        (r_row == RW'(NUM_ROWS))) begin
                        n_scrolled = 1'b1;
                        n_state    = tcw_pkg::S_SCROLL;
                    end else if (i_req.req_type == tcw_pkg::REQ_CLEAR) begin
                        n_state = tcw_pkg::S_CLEAR;
                    end else begin
                        n_state = tcw_pkg::S_EXEC;
                    end
                end
            end

            tcw_pkg::S_SCROLL: begin
                // Read one row ahead, write the previous beat's data one row up
                if (r_cp_vld) begin
                    w_we    = 1'b1;
                    w_waddr = r_cp_addr;
                    w_wdata = w_rdata;
                end
                n_cp_vld  = 1'b1;
                n_cp_addr = r_idx;
                n_idx     = AW'(r_idx + AW'(1));
                if (r_idx == AW'(COPY_N - 1)) begin
                    n_state = tcw_pkg::S_BLANK;
                end
            end

            tcw_pkg::S_BLANK: begin
                // Drain the last copy, then blank the bottom row
                w_we = 1'b1;
                if (r_cp_vld) begin
                    w_waddr  = r_cp_addr;
                    w_wdata  = w_rdata;
                    n_cp_vld = 1'b0;
                end else begin
                    n_idx = AW'(r_idx + AW'(1));
                    if (r_idx == AW'(CELLS - 1)) begin
                        n_row   = RW'(r_row - RW'(1));
                        n_state = tcw_pkg::S_EXEC;
                    end
                end
            end

            tcw_pkg::S_CLEAR: begin
                w_we  = 1'b1;
                n_idx = AW'(r_idx + AW'(1));
                if (r_idx == AW'(CELLS - 1)) begin
                    n_col = '0;
                    n_row = '0;
                    n_hw  = '0;
                    w_fin = 1'b1;
                end
            end

            tcw_pkg::S_EXEC: begin
                unique case (r_req_type)
                    tcw_pkg::REQ_PUT: begin
                        if (w_newline) begin
                            n_col = '0;
                            n_row = RW'(r_row + RW'(1));
                            if (r_scrolled) begin
                                n_hw = HW'(w_lin);
                            end
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = w_lin;
                            w_wdata = {r_attr, r_char};
                            if (r_col == CW'(NUM_COLS - 1)) begin
                                n_col = '0;
                                n_row = RW'(r_row + RW'(1));
                            end else begin
                                n_col = CW'(r_col + CW'(1));
                            end
                            n_hw = HW'(w_lin_inc);
                        end
                        w_fin = 1'b1;
                    end
                    tcw_pkg::REQ_MOVE: begin
                        n_col = r_satx;
                        n_row = r_saty;
                        n_hw  = HW'(w_lin);
                        w_fin = 1'b1;
                    end
                    tcw_pkg::REQ_READ: begin
                        w_raddr = w_lin;
                        n_state = tcw_pkg::S_RDATA;
                    end
                    default: begin
                        w_fin = 1'b1;
                    end
                endcase
            end

            tcw_pkg::S_RDATA: begin
                w_fin = 1'b1;
                if (r_in_rng) begin
                    w_f_char = w_rdata[CHW-1:0];
                    w_f_attr = w_rdata[tcw_pkg::CELL_W-1:CHW];
                end
            end

            tcw_pkg::S_HOLD: begin
                if (w_out_free) begin
                    n_o_valid    = 1'b1;
                    n_o_cursor   = r_hw;
                    n_o_char     = r_res_char;
                    n_o_attr     = r_res_attr;
                    n_o_scrolled = r_scrolled;
                    n_state      = tcw_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = tcw_pkg::S_IDLE;
            end
        endcase

        // Finish: load the response, or park it until the output frees up
        if (w_fin) begin
            n_res_char = w_f_char;
            n_res_attr = w_f_attr;
            if (w_out_free) begin
                n_o_valid    = 1'b1;
                n_o_cursor   = n_hw;
                n_o_char     = w_f_char;
                n_o_attr     = w_f_attr;
                n_o_scrolled = r_scrolled;
                n_state      = tcw_pkg::S_IDLE;
            end else begin
                n_state = tcw_pkg::S_HOLD;
            end
        end
    end

    // Response channel
    assign o_rsp.valid      = r_o_valid;
    assign o_rsp.cursor_pos = r_o_cursor;
    assign o_rsp.read_char  = r_o_char;
    assign o_rsp.read_attr  = r_o_attr;
    assign o_rsp.scrolled   = r_o_scrolled;

    // Cursor stays on screen, with the row allowed one past the bottom
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= RW'(NUM_ROWS))
        else $error("cursor row beyond screen");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= CW'(NUM_COLS - 1))
        else $error("cursor column beyond screen");

    // One request in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("request taken while another is in work");

    // Memory writes only while a request is in work
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tcw_pkg::S_IDLE |-> !w_we)
        else $error("cell write while idle");

    // Pending copy beat lives only inside a scroll
    a_copy_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_vld |-> (r_state == tcw_pkg::S_SCROLL) || (r_state == tcw_pkg::S_BLANK))
        else $error("copy beat pending outside scroll");

endmodule
